// ----- hdl/spq_pkg.sv -----
// Shared types and constants for the sorted max priority queue.
// Used by spq_cell and sorted_max_priority_queue; depends on nothing.
package spq_pkg;

  // Queue capacity and counter width (the counter must hold DEPTH itself)
  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Request kinds carried on tuser
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Operation broadcast to every cell of the chain
  typedef struct packed {
    logic               push;   // insert value (queue not full)
    logic               pop;    // remove top (queue not empty)
    logic signed [31:0] value;
  } spq_ctrl_t;

endpackage

// ----- hdl/sorted_max_priority_queue.sv -----
// The result of an accepted request is captured in the output register when it is accepted.
// Throughput: one push or pop per cycle unless stalled; all entries update at once.
// Input is taken whenever the output register is empty or being drained.
// Reset clears the entry count and the output valid; cell contents stay undefined
// and are never read before being written.
// Top level: chain of spq_cell instances plus occupancy counter and result register.
// Depends on spq_pkg and spq_cell.
module sorted_max_priority_queue
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] top_value, [32] is_empty,
                                        // [37:33] entry_count, [38] push_rejected, [39] zero
);

  logic             accept;
  logic             full, empty;
  logic [CNT_W-1:0] count_q, count_d;
  spq_ctrl_t        ctrl;

  logic               ins   [DEPTH];
  logic signed [31:0] ent   [DEPTH];
  logic signed [31:0] ent_d [DEPTH];

  logic               out_valid_q, out_valid_d;
  logic [39:0]        out_data_q, out_data_d;
  logic               rejected;
  logic [4:0]         count_out;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // Broadcast the request; drop a push on a full queue and a pop on an empty one
  always_comb begin
    ctrl.value = s_axis_tdata_i;
    ctrl.push  = accept && (s_axis_tuser_i == KIND_PUSH) && !full;
    ctrl.pop   = accept && (s_axis_tuser_i == KIND_POP) && !empty;
  end
  assign rejected = (s_axis_tuser_i == KIND_PUSH) && full;

  // Chain of cells, position 0 holds the largest value
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               prev_ins;
    logic signed [31:0] prev_entry, next_entry;
    if (i == 0) begin : g_first
      assign prev_ins   = 1'b0;
      assign prev_entry = '0;
    end else begin : g_mid
      assign prev_ins   = ins[i-1];
      assign prev_entry = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_entry = ent[i];
    end else begin : g_body
      assign next_entry = ent[i+1];
    end
    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (count_q > CNT_W'(i)),
      .prev_ins_i   (prev_ins),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .ins_o        (ins[i]),
      .entry_o      (ent[i]),
      .entry_d_o    (ent_d[i])
    );
  end

  // Advance the occupancy count
  always_comb begin
    count_d = count_q;
    if (ctrl.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Build the result from the state after this request
  assign count_out = 5'(count_d);
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (accept) begin
      out_valid_d = 1'b1;
      out_data_d  = {1'b0, rejected, count_out, (count_d == '0),
                     (count_d == '0) ? 32'd0 : ent_d[0]};
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Check the entries below the count are in descending order
  logic sorted_ok;
  always_comb begin
    sorted_ok = 1'b1;
    for (int k = 1; k < DEPTH; k++) begin
      if ((count_q > CNT_W'(k)) && (ent[k] > ent[k-1])) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("occupancy exceeds capacity");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni) sorted_ok)
    else $error("entries out of order");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser_i == KIND_PUSH && full) |=> (m_axis_tdata_o[38] && $stable(count_q)))
    else $error("push on full queue not rejected");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(accept) |-> (m_axis_tdata_o[32] == (count_q == '0)))
    else $error("empty flag disagrees with count");

endmodule

// ----- hdl/spq_cell.sv -----
// One storage cell of the sorted chain: holds one entry and shifts it to or from its neighbors.
// Depends on spq_pkg for the broadcast control struct.
module spq_cell
  import spq_pkg::*;
(
  input  logic               clk_i,
  input  spq_ctrl_t          ctrl_i,
  input  logic               valid_i,       // this position holds an entry
  input  logic               prev_ins_i,    // left neighbor is at or past the insert point
  input  logic signed [31:0] prev_entry_i,  // entry of left neighbor
  input  logic signed [31:0] next_entry_i,  // entry of right neighbor
  output logic               ins_o,         // this cell is at or past the insert point
  output logic signed [31:0] entry_o,
  output logic signed [31:0] entry_d_o      // value held after this cycle
);

  logic signed [31:0] entry_q, entry_d;

  // Insert point: first empty position or first entry smaller than the new value
  assign ins_o = !valid_i || (ctrl_i.value > entry_q);

  // Shift right on insert, shift left on pop, else hold
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push && ins_o) begin
      entry_d = prev_ins_i ? prev_entry_i : ctrl_i.value;
    end else if (ctrl_i.pop) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule
